// ===== hw/rtl/opa_pkg.sv =====
// Shared constants and types for the odometry pose aligner.
package opa_pkg;

   // Register indexes on the configuration port
   typedef logic [2:0] csr_idx_type;
   localparam csr_idx_type CSR_WAIT     = 3'd0;
   localparam csr_idx_type CSR_ZERO     = 3'd1;
   localparam csr_idx_type CSR_LOCK     = 3'd2;
   localparam csr_idx_type CSR_MAN_X    = 3'd3;
   localparam csr_idx_type CSR_MAN_Y    = 3'd4;
   localparam csr_idx_type CSR_MAN_YAW  = 3'd5;

   // Extra fraction bits carried through the CORDIC datapath
   localparam int GUARD_BITS = 8;

   // CORDIC gain compensation, 1/K in Q30, applied in chunks of MUL_CHUNK bits
   localparam int          GAIN_W    = 30;
   localparam int          MUL_CHUNK = 16;
   localparam logic [29:0] GAIN_Q30  = 30'd652032874;

   // Arctangent table, 32-bit binary angle (2^31 equals pi)
   localparam int ATAN_LEN = 24;
   typedef logic [4:0] atan_idx_type;
   localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

endpackage

// ===== hw/rtl/odometry_pose_aligner_unit.sv =====
// Planar pose aligner: composes odometry poses with a map pose using one shared CORDIC unit.
// Sequence: a map-pose request is taken while idle and gives no result. An odometry request
//   runs R rotations through the CORDIC (pre-scale, micro-rotations, gain multiply of x then y
//   in chunks of C = ceil((COORD_WIDTH+12)/16), post step), where R is 3 with the zero register
//   set, else 2; the one CORDIC stage and the 16x30 gain multiplier serve every rotation.
// Throughput: one odometry request at a time; ready again once the result is in the output register.
// Reset: synchronous, active high; clears the held pose, the origin and the sequencer, and
//   returns the configuration registers to wait, zero and lock set with a zero manual pose.
module odometry_pose_aligner_unit #(
   parameter int COORD_WIDTH  = 32,
   parameter int ANGLE_WIDTH  = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic clock,
   input  logic reset,
   // request channel
   input  logic req_tvalid,
   output logic req_tready,
   // pos_x, pos_y, heading, vel_x, vel_y (lowest bits first)
   input  logic [(((4 * COORD_WIDTH + ANGLE_WIDTH) + 7) / 8) * 8 - 1:0] req_tdata,
   // req_type: 0 map pose, 1 odometry
   input  logic req_tuser,
   // result channel
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // frame_x, frame_y, aligned_heading, map_vel_x, map_vel_y (lowest bits first)
   output logic [(((4 * COORD_WIDTH + ANGLE_WIDTH) + 7) / 8) * 8 - 1:0] rsp_tdata,
   // configuration write channel
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [2:0] csr_index,
   input  logic [((COORD_WIDTH > ANGLE_WIDTH) ? COORD_WIDTH : ANGLE_WIDTH) - 1:0] csr_data
);

   localparam int CW      = COORD_WIDTH;
   localparam int AWD     = ANGLE_WIDTH;
   localparam int PAY_W   = 4 * CW + AWD;
   localparam int TDATA_W = ((PAY_W + 7) / 8) * 8;
   localparam int DW      = CW + 12;
   localparam int ZW      = 33;
   localparam int ASH     = 32 - AWD;
   localparam int CHUNKS  = (DW + opa_pkg::MUL_CHUNK - 1) / opa_pkg::MUL_CHUNK;
   localparam int MAGW    = CHUNKS * opa_pkg::MUL_CHUNK;
   localparam int ACCW    = MAGW + opa_pkg::GAIN_W;
   localparam int MPW     = opa_pkg::MUL_CHUNK + opa_pkg::GAIN_W;
   localparam int KW      = $clog2(CORDIC_STEPS);

   localparam logic signed [DW-1:0] SAT_HI = {{(DW - CW + 1){1'b0}}, {(CW - 1){1'b1}}};
   localparam logic signed [DW-1:0] SAT_LO = {{(DW - CW + 1){1'b1}}, {(CW - 1){1'b0}}};
   localparam logic signed [DW:0]   HALF_LSB = (DW + 1)'(1) << (opa_pkg::GUARD_BITS - 1);
   localparam logic [ACCW-1:0]      HALF_Q30 = ACCW'(1) << (opa_pkg::GAIN_W - 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_PRE, ST_ITER, ST_GLOAD, ST_GAIN, ST_GFIN, ST_POST, ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      ROT_ORIGIN, ROT_POSE, ROT_VEL
   } rot_type;

   // sequencer
   state_type state_ff, state_in;
   rot_type   rot_ff, rot_in;
   logic      gsel_ff, gsel_in;
   logic [KW-1:0] cnt_ff, cnt_in;

   // shared CORDIC and gain datapath
   logic signed [DW-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [ZW-1:0] z_ff, z_in;
   logic [31:0]          ang_ff, ang_in;
   logic [MAGW-1:0]      mag_ff, mag_in;
   logic                 neg_ff, neg_in;
   logic [ACCW-1:0]      acc_ff, acc_in;

   // per-request operands and partial results
   logic [CW-1:0]  mx_ff, mx_in, my_ff, my_in;
   logic [AWD-1:0] myaw_ff, myaw_in, hd_res_ff, hd_res_in;
   logic [CW-1:0]  vx_ff, vx_in, vy_ff, vy_in;
   logic [CW-1:0]  posx_ff, posx_in, posy_ff, posy_in;

   // configuration registers
   logic           wait_ff, wait_in, zero_ff, zero_in, lock_ff, lock_in;
   logic [CW-1:0]  man_x_ff, man_x_in, man_y_ff, man_y_in;
   logic [AWD-1:0] man_yaw_ff, man_yaw_in;

   // alignment state
   logic           pose_rcvd_ff, pose_rcvd_in, org_valid_ff, org_valid_in;
   logic [CW-1:0]  map_x_ff, map_x_in, map_y_ff, map_y_in;
   logic [AWD-1:0] map_yaw_ff, map_yaw_in;
   logic [CW-1:0]  org_x_ff, org_x_in, org_y_ff, org_y_in;
   logic [AWD-1:0] org_yaw_ff, org_yaw_in;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [PAY_W-1:0] rsp_data_ff, rsp_data_in;

   // unpack the request
   logic [CW-1:0]  in_px, in_py, in_vx, in_vy;
   logic [AWD-1:0] in_hd;
   logic           held;

   assign in_px = req_tdata[CW-1:0];
   assign in_py = req_tdata[2*CW-1:CW];
   assign in_hd = req_tdata[2*CW +: AWD];
   assign in_vx = req_tdata[2*CW+AWD +: CW];
   assign in_vy = req_tdata[3*CW+AWD +: CW];
   assign held  = pose_rcvd_ff || !wait_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_W'(rsp_data_ff);
   assign csr_ready  = 1'b1;

   // magnitude of a signed datapath value, widened to the multiplier input
   function automatic logic [MAGW-1:0] abs_mag(input logic signed [DW-1:0] v);
      logic [DW-1:0] m;
      m = v[DW-1] ? DW'(-v) : DW'(v);
      return MAGW'(m);
   endfunction

   // clamp a datapath value to the coordinate range
   function automatic logic [CW-1:0] sat_coord(input logic signed [DW-1:0] v);
      logic [CW-1:0] r;
      if (v > SAT_HI) begin
         r = {1'b0, {(CW - 1){1'b1}}};
      end else if (v < SAT_LO) begin
         r = {1'b1, {(CW - 1){1'b0}}};
      end else begin
         r = v[CW-1:0];
      end
      return r;
   endfunction

   // next-state logic for sequencer, datapath and registers
   always_comb begin
      logic                 capture;
      logic [CW-1:0]        ox, oy;
      logic [AWD-1:0]       oyaw, yaw_sel;
      logic signed [CW:0]   dx, dy;
      logic signed [DW-1:0] cxs, cys, sx, sy;
      logic [31:0]          a_q, a_h;
      logic signed [ZW-1:0] atan;
      logic [MPW-1:0]       prod;
      logic [ACCW-1:0]      rnd;
      logic [DW-1:0]        r_dw;
      logic signed [DW:0]   rs, rsum, rshift;

      capture = 1'b0;
      ox      = org_x_ff;
      oy      = org_y_ff;
      oyaw    = org_yaw_ff;
      yaw_sel = pose_rcvd_ff ? map_yaw_ff : man_yaw_ff;
      dx      = '0;
      dy      = '0;
      cxs     = cx_ff <<< opa_pkg::GUARD_BITS;
      cys     = cy_ff <<< opa_pkg::GUARD_BITS;
      sx      = cx_ff >>> cnt_ff;
      sy      = cy_ff >>> cnt_ff;
      a_q     = ang_ff + 32'h4000_0000;
      a_h     = ang_ff + 32'h8000_0000;
      atan    = {1'b0, opa_pkg::ATAN_TAB[opa_pkg::atan_idx_type'(cnt_ff)]};
      prod    = MPW'(mag_ff[MAGW-1 -: opa_pkg::MUL_CHUNK]) * MPW'(opa_pkg::GAIN_Q30);
      rnd     = acc_ff + HALF_Q30;
      r_dw    = rnd[opa_pkg::GAIN_W +: DW];
      rs      = neg_ff ? -$signed({1'b0, r_dw}) : $signed({1'b0, r_dw});
      rsum    = rs + HALF_LSB;
      rshift  = rsum >>> opa_pkg::GUARD_BITS;

      state_in     = state_ff;
      rot_in       = rot_ff;
      gsel_in      = gsel_ff;
      cnt_in       = cnt_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      z_in         = z_ff;
      ang_in       = ang_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      acc_in       = acc_ff;
      mx_in        = mx_ff;
      my_in        = my_ff;
      myaw_in      = myaw_ff;
      hd_res_in    = hd_res_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      posx_in      = posx_ff;
      posy_in      = posy_ff;
      wait_in      = wait_ff;
      zero_in      = zero_ff;
      lock_in      = lock_ff;
      man_x_in     = man_x_ff;
      man_y_in     = man_y_ff;
      man_yaw_in   = man_yaw_ff;
      pose_rcvd_in = pose_rcvd_ff;
      org_valid_in = org_valid_ff;
      map_x_in     = map_x_ff;
      map_y_in     = map_y_ff;
      map_yaw_in   = map_yaw_ff;
      org_x_in     = org_x_ff;
      org_y_in     = org_y_ff;
      org_yaw_in   = org_yaw_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      // take configuration writes, drop unknown indexes
      if (csr_valid) begin
         case (csr_index)
            opa_pkg::CSR_WAIT:    wait_in    = csr_data[0];
            opa_pkg::CSR_ZERO:    zero_in    = csr_data[0];
            opa_pkg::CSR_LOCK:    lock_in    = csr_data[0];
            opa_pkg::CSR_MAN_X:   man_x_in   = csr_data[CW-1:0];
            opa_pkg::CSR_MAN_Y:   man_y_in   = csr_data[CW-1:0];
            opa_pkg::CSR_MAN_YAW: man_yaw_in = csr_data[AWD-1:0];
            default: ;
         endcase
      end

      // release the output register once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (!req_tuser) begin
                  // map pose: store unless locked while a pose is held
                  if (!(lock_ff && held)) begin
                     map_x_in     = in_px;
                     map_y_in     = in_py;
                     map_yaw_in   = in_hd;
                     pose_rcvd_in = 1'b1;
                     org_valid_in = 1'b0;
                  end
               end else if (held) begin
                  // odometry: capture origin if needed and load the first rotation
                  capture = zero_ff && !org_valid_ff;
                  if (capture) begin
                     ox           = in_px;
                     oy           = in_py;
                     oyaw         = in_hd;
                     org_x_in     = in_px;
                     org_y_in     = in_py;
                     org_yaw_in   = in_hd;
                     org_valid_in = 1'b1;
                  end
                  mx_in   = pose_rcvd_ff ? map_x_ff : man_x_ff;
                  my_in   = pose_rcvd_ff ? map_y_ff : man_y_ff;
                  myaw_in = yaw_sel;
                  vx_in   = in_vx;
                  vy_in   = in_vy;
                  if (zero_ff) begin
                     dx        = $signed({in_px[CW-1], in_px}) - $signed({ox[CW-1], ox});
                     dy        = $signed({in_py[CW-1], in_py}) - $signed({oy[CW-1], oy});
                     cx_in     = {{(DW - CW - 1){dx[CW]}}, dx};
                     cy_in     = {{(DW - CW - 1){dy[CW]}}, dy};
                     ang_in    = 32'd0 - {oyaw, {ASH{1'b0}}};
                     hd_res_in = yaw_sel + (in_hd - oyaw);
                     rot_in    = ROT_ORIGIN;
                  end else begin
                     cx_in     = {{(DW - CW){in_px[CW-1]}}, in_px};
                     cy_in     = {{(DW - CW){in_py[CW-1]}}, in_py};
                     ang_in    = {yaw_sel, {ASH{1'b0}}};
                     hd_res_in = yaw_sel + in_hd;
                     rot_in    = ROT_POSE;
                  end
                  state_in = ST_PRE;
               end
            end
         end

         ST_PRE: begin
            // scale up and fold the angle into the half circle around zero
            if (a_q[31]) begin
               cx_in = -cxs;
               cy_in = -cys;
               z_in  = {a_h[31], a_h};
            end else begin
               cx_in = cxs;
               cy_in = cys;
               z_in  = {ang_ff[31], ang_ff};
            end
            cnt_in   = '0;
            state_in = ST_ITER;
         end

         ST_ITER: begin
            // one micro-rotation per cycle
            if (!z_ff[ZW-1]) begin
               cx_in = cx_ff - sy;
               cy_in = cy_ff + sx;
               z_in  = z_ff - atan;
            end else begin
               cx_in = cx_ff + sy;
               cy_in = cy_ff - sx;
               z_in  = z_ff + atan;
            end
            if (cnt_ff == KW'(CORDIC_STEPS - 1)) begin
               state_in = ST_GLOAD;
            end else begin
               cnt_in = cnt_ff + KW'(1);
            end
         end

         ST_GLOAD: begin
            neg_in   = cx_ff[DW-1];
            mag_in   = abs_mag(cx_ff);
            acc_in   = '0;
            cnt_in   = '0;
            gsel_in  = 1'b0;
            state_in = ST_GAIN;
         end

         ST_GAIN: begin
            // multiply by the gain, top chunk first
            acc_in = (acc_ff << opa_pkg::MUL_CHUNK) + ACCW'(prod);
            mag_in = mag_ff << opa_pkg::MUL_CHUNK;
            if (cnt_ff == KW'(CHUNKS - 1)) begin
               state_in = ST_GFIN;
            end else begin
               cnt_in = cnt_ff + KW'(1);
            end
         end

         ST_GFIN: begin
            // round and drop the guard bits; start y after x
            if (!gsel_ff) begin
               cx_in    = rshift[DW-1:0];
               neg_in   = cy_ff[DW-1];
               mag_in   = abs_mag(cy_ff);
               acc_in   = '0;
               cnt_in   = '0;
               gsel_in  = 1'b1;
               state_in = ST_GAIN;
            end else begin
               cy_in    = rshift[DW-1:0];
               state_in = ST_POST;
            end
         end

         ST_POST: begin
            case (rot_ff)
               ROT_ORIGIN: begin
                  ang_in   = {myaw_ff, {ASH{1'b0}}};
                  rot_in   = ROT_POSE;
                  state_in = ST_PRE;
               end
               ROT_POSE: begin
                  posx_in  = cx_ff[CW-1:0] + mx_ff;
                  posy_in  = cy_ff[CW-1:0] + my_ff;
                  cx_in    = {{(DW - CW){vx_ff[CW-1]}}, vx_ff};
                  cy_in    = {{(DW - CW){vy_ff[CW-1]}}, vy_ff};
                  rot_in   = ROT_VEL;
                  state_in = ST_PRE;
               end
               ROT_VEL: begin
                  state_in = ST_OUT;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end

         ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {sat_coord(cy_ff), sat_coord(cx_ff), hd_res_ff, posy_ff, posx_ff};
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state, control and payload registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rot_ff       <= ROT_POSE;
         gsel_ff      <= 1'b0;
         cnt_ff       <= '0;
         wait_ff      <= 1'b1;
         zero_ff      <= 1'b1;
         lock_ff      <= 1'b1;
         man_x_ff     <= '0;
         man_y_ff     <= '0;
         man_yaw_ff   <= '0;
         pose_rcvd_ff <= 1'b0;
         org_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rot_ff       <= rot_in;
         gsel_ff      <= gsel_in;
         cnt_ff       <= cnt_in;
         wait_ff      <= wait_in;
         zero_ff      <= zero_in;
         lock_ff      <= lock_in;
         man_x_ff     <= man_x_in;
         man_y_ff     <= man_y_in;
         man_yaw_ff   <= man_yaw_in;
         pose_rcvd_ff <= pose_rcvd_in;
         org_valid_ff <= org_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      z_ff        <= z_in;
      ang_ff      <= ang_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      acc_ff      <= acc_in;
      mx_ff       <= mx_in;
      my_ff       <= my_in;
      myaw_ff     <= myaw_in;
      hd_res_ff   <= hd_res_in;
      vx_ff       <= vx_in;
      vy_ff       <= vy_in;
      posx_ff     <= posx_in;
      posy_ff     <= posy_in;
      map_x_ff    <= map_x_in;
      map_y_ff    <= map_y_in;
      map_yaw_ff  <= map_yaw_in;
      org_x_ff    <= org_x_in;
      org_y_ff    <= org_y_in;
      org_yaw_ff  <= org_yaw_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTH
   // an accepted map pose that is not locked out is held and drops the origin
   a_map_clears_origin: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !req_tuser && !(lock_ff && (pose_rcvd_ff || !wait_ff)))
      |=> (pose_rcvd_ff && !org_valid_ff))
      else $error("map pose request did not update alignment state");

   // an odometry request with a held pose keeps the block busy
   a_busy_after_odo: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser && (pose_rcvd_ff || !wait_ff))
      |=> (!req_tready && (state_ff == ST_PRE)))
      else $error("odometry request did not start the rotation sequence");

   // a finished result waits while the output register is still full
   a_out_waits: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_OUT) && rsp_tvalid && !rsp_tready)
      |=> ((state_ff == ST_OUT) && rsp_tvalid))
      else $error("result overwrote an untaken output");

   // CORDIC step counter stays inside the arctangent schedule
   a_iter_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ITER) |-> (cnt_ff <= KW'(CORDIC_STEPS - 1)))
      else $error("CORDIC step counter out of range");
`endif

endmodule
